FILE: sv/ptpd_pkg.sv
package ptpd_pkg;

  localparam int COORD_BITS  = 24;
  localparam int U_FRAC_BITS = 16;

  localparam int DIFF_BITS   = COORD_BITS + 1;
  localparam int DMAG_BITS   = COORD_BITS + 2;
  localparam int MUL_IN_BITS = (COORD_BITS + 2 > U_FRAC_BITS + 1) ? COORD_BITS + 2
                                                                   : U_FRAC_BITS + 1;
  localparam int PROD_BITS   = 2 * MUL_IN_BITS;
  localparam int ACC_BITS    = 2 * COORD_BITS + 4;
  localparam int SQ_BITS     = 2 * COORD_BITS + 2;
  localparam int DIST_BITS   = COORD_BITS + 1;
  localparam int UQ_BITS     = U_FRAC_BITS + 1;
  localparam int STEP_MAX    = (DIST_BITS > U_FRAC_BITS) ? DIST_BITS : U_FRAC_BITS;
  localparam int CNT_BITS    = $clog2(STEP_MAX);
  localparam int MAC_STEPS   = 6;
  localparam int AXES        = 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_LEN,
    OP_DOT,
    OP_DIVSET,
    OP_DIV,
    OP_OFS,
    OP_SQ,
    OP_UPD,
    OP_ROOT_INIT,
    OP_ROOT,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] axis;
  } ctrl_cmd_t;

  typedef struct packed {
    logic first;
    logic last;
    logic seen;
    logic out_busy;
  } dp_status_t;

endpackage

FILE: sv/ptpd_if.sv
interface ptpd_in_if import ptpd_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t vertex_x;
  coord_t vertex_y;
  coord_t vertex_z;
  coord_t query_x;
  coord_t query_y;
  coord_t query_z;
  logic   first_vertex;
  logic   last_vertex;

  modport source(output valid, vertex_x, vertex_y, vertex_z, query_x, query_y, query_z,
                 first_vertex, last_vertex, input ready);
  modport sink(input valid, vertex_x, vertex_y, vertex_z, query_x, query_y, query_z,
               first_vertex, last_vertex, output ready);
endinterface

interface ptpd_out_if import ptpd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [DIST_BITS-1:0] distance_mm;
  logic                 no_segment;

  modport source(output valid, distance_mm, no_segment, input ready);
  modport sink(input valid, distance_mm, no_segment, output ready);
endinterface

FILE: sv/point_to_polyline_distance.sv
// Least distance from a query point to a streamed polyline. One vertex is a request;
// the query point rides along with every vertex. A first vertex passes accept, check and
// finish; every later vertex passes accept, check, 6 multiply-accumulate steps on the one
// shared multiplier, divider setup, U_FRAC_BITS = 16 steps of the restoring divider for u,
// 3 offset and 3 square steps, update and finish. A last vertex then runs 25 steps of the
// bit-serial square root, one result bit a cycle, when a segment was seen, and in either
// case loads the output register once the previous result has left it. A new vertex is
// taken while a result still waits at the output.
module point_to_polyline_distance import ptpd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,
  ptpd_in_if.sink      in_i,
  ptpd_out_if.source   out_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;

  assign in_i.ready = in_ready;

  ptpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ptpd_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .vertex_x_i     (in_i.vertex_x),
    .vertex_y_i     (in_i.vertex_y),
    .vertex_z_i     (in_i.vertex_z),
    .query_x_i      (in_i.query_x),
    .query_y_i      (in_i.query_y),
    .query_z_i      (in_i.query_z),
    .first_vertex_i (in_i.first_vertex),
    .last_vertex_i  (in_i.last_vertex),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .distance_mm_o  (out_o.distance_mm),
    .no_segment_o   (out_o.no_segment)
  );

endmodule

FILE: sv/ptpd_ctrl.sv
module ptpd_ctrl import ptpd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b00000000001,
    ST_MAC    = 11'b00000000010,
    ST_DIVSET = 11'b00000000100,
    ST_DIV    = 11'b00000001000,
    ST_OFS    = 11'b00000010000,
    ST_SQ     = 11'b00000100000,
    ST_UPD    = 11'b00001000000,
    ST_FINISH = 11'b00010000000,
    ST_ROOT   = 11'b00100000000,
    ST_EMIT   = 11'b01000000000,
    ST_CHECK  = 11'b10000000000
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cmd_o.op   = OP_NONE;
    cmd_o.axis = 2'd0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cnt_d   = '0;
        state_d = status_i.first ? ST_FINISH : ST_MAC;
      end
      ST_MAC: begin
        cmd_o.op   = cnt_q[0] ? OP_DOT : OP_LEN;
        cmd_o.axis = cnt_q[2:1];
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == CNT_BITS'(MAC_STEPS - 1)) begin
          state_d = ST_DIVSET;
        end
      end
      ST_DIVSET: begin
        cmd_o.op = OP_DIVSET;
        cnt_d    = '0;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.op = OP_DIV;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CNT_BITS'(U_FRAC_BITS - 1)) begin
          cnt_d   = '0;
          state_d = ST_OFS;
        end
      end
      ST_OFS: begin
        cmd_o.op   = OP_OFS;
        cmd_o.axis = cnt_q[1:0];
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == CNT_BITS'(AXES - 1)) begin
          cnt_d   = '0;
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd_o.op   = OP_SQ;
        cmd_o.axis = cnt_q[1:0];
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == CNT_BITS'(AXES - 1)) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd_o.op = OP_UPD;
        state_d  = ST_FINISH;
      end
      ST_FINISH: begin
        cnt_d = '0;
        priority if (!status_i.last) begin
          state_d = ST_IDLE;
        end else if (status_i.seen) begin
          cmd_o.op = OP_ROOT_INIT;
          state_d  = ST_ROOT;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_ROOT: begin
        cmd_o.op = OP_ROOT;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CNT_BITS'(DIST_BITS - 1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // hold the result until the output register frees up
        if (!status_i.out_busy) begin
          cmd_o.op = OP_EMIT;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

FILE: sv/ptpd_datapath.sv
module ptpd_datapath import ptpd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  coord_t               vertex_x_i,
  input  coord_t               vertex_y_i,
  input  coord_t               vertex_z_i,
  input  coord_t               query_x_i,
  input  coord_t               query_y_i,
  input  coord_t               query_z_i,
  input  logic                 first_vertex_i,
  input  logic                 last_vertex_i,
  input  ctrl_cmd_t            cmd_i,
  output dp_status_t           status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [DIST_BITS-1:0] distance_mm_o,
  output logic                 no_segment_o
);

  localparam int W = COORD_BITS + 3;
  localparam logic [SQ_BITS-1:0] SQ_MAX = '1;

  logic                 use_height_q;
  coord_t               prev_x_q, prev_y_q, prev_z_q;
  diff_t                s_q [AXES];
  diff_t                w_q [AXES];
  logic [DMAG_BITS-1:0] dm_q [AXES];
  logic                 first_q, last_q, seen_q;
  logic [ACC_BITS-1:0]  len2_q, pos_q, neg_q, sum_q;
  logic [ACC_BITS-1:0]  rem_q;
  logic [UQ_BITS-1:0]   uq_q;
  logic                 div_run_q;
  logic [SQ_BITS-1:0]   least_q;
  logic [SQ_BITS-1:0]   n_q;
  logic [DIST_BITS+1:0] rrem_q;
  logic [DIST_BITS-1:0] root_q;
  logic                 out_valid_q;
  logic [DIST_BITS-1:0] dist_q;
  logic                 noseg_q;

  diff_t                  s_sel, w_sel;
  logic [DIFF_BITS-1:0]   s_mag, w_mag;
  logic [MUL_IN_BITS-1:0] mul_a, mul_b;
  logic [PROD_BITS-1:0]   mul_p;
  logic [PROD_BITS-1:0]   rnd;
  logic [DMAG_BITS-1:0]   m_mag;
  logic signed [W-1:0]    off, dval;
  logic [ACC_BITS-1:0]    pn_diff;
  logic [ACC_BITS:0]      r2;
  logic [SQ_BITS-1:0]     sat;
  logic [DIST_BITS+3:0]   rrem2, rtrial;

  assign s_sel = s_q[cmd_i.axis];
  assign w_sel = w_q[cmd_i.axis];
  assign s_mag = s_sel[DIFF_BITS-1] ? DIFF_BITS'(-s_sel) : DIFF_BITS'(s_sel);
  assign w_mag = w_sel[DIFF_BITS-1] ? DIFF_BITS'(-w_sel) : DIFF_BITS'(w_sel);

  always_comb begin
    mul_a = MUL_IN_BITS'(s_mag);
    mul_b = MUL_IN_BITS'(s_mag);
    unique case (cmd_i.op)
      OP_DOT:  mul_b = MUL_IN_BITS'(w_mag);
      OP_OFS:  mul_b = MUL_IN_BITS'(uq_q);
      OP_SQ: begin
        mul_a = MUL_IN_BITS'(dm_q[cmd_i.axis]);
        mul_b = MUL_IN_BITS'(dm_q[cmd_i.axis]);
      end
      default: mul_b = MUL_IN_BITS'(s_mag);
    endcase
  end

  assign mul_p = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);

  // round half away from zero on the magnitude, then restore the sign
  assign rnd   = mul_p + (PROD_BITS'(1) << (U_FRAC_BITS - 1));
  assign m_mag = rnd[U_FRAC_BITS +: DMAG_BITS];
  assign off   = s_sel[DIFF_BITS-1] ? -$signed({1'b0, m_mag}) : $signed({1'b0, m_mag});
  assign dval  = W'(w_sel) - off;

  assign pn_diff = pos_q - neg_q;
  assign r2      = {rem_q, 1'b0};
  assign sat     = (sum_q > ACC_BITS'(SQ_MAX)) ? SQ_MAX : SQ_BITS'(sum_q);
  assign rrem2   = {rrem_q, n_q[SQ_BITS-1 -: 2]};
  assign rtrial  = {2'b00, root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_height_q <= 1'b1;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      prev_z_q     <= '0;
      least_q      <= SQ_MAX;
      seen_q       <= 1'b0;
      first_q      <= 1'b0;
      last_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        use_height_q <= cfg_wdata_i;
      end
      if (cmd_i.op == OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i.op)
        OP_LOAD: begin
          prev_x_q <= vertex_x_i;
          prev_y_q <= vertex_y_i;
          prev_z_q <= vertex_z_i;
          first_q  <= first_vertex_i;
          last_q   <= last_vertex_i;
          if (first_vertex_i) begin
            least_q <= SQ_MAX;
            seen_q  <= 1'b0;
          end
        end
        OP_UPD: begin
          if (sat < least_q) begin
            least_q <= sat;
          end
          seen_q <= 1'b1;
        end
        OP_EMIT: begin
          least_q <= SQ_MAX;
          seen_q  <= 1'b0;
        end
        default: begin
          seen_q <= seen_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        s_q[0] <= DIFF_BITS'(vertex_x_i) - DIFF_BITS'(prev_x_q);
        s_q[1] <= DIFF_BITS'(vertex_y_i) - DIFF_BITS'(prev_y_q);
        w_q[0] <= DIFF_BITS'(query_x_i) - DIFF_BITS'(prev_x_q);
        w_q[1] <= DIFF_BITS'(query_y_i) - DIFF_BITS'(prev_y_q);
        // drop z entirely in planar mode
        s_q[2] <= use_height_q ? DIFF_BITS'(vertex_z_i) - DIFF_BITS'(prev_z_q) : '0;
        w_q[2] <= use_height_q ? DIFF_BITS'(query_z_i) - DIFF_BITS'(prev_z_q) : '0;
        len2_q <= '0;
        pos_q  <= '0;
        neg_q  <= '0;
      end
      OP_LEN: len2_q <= len2_q + ACC_BITS'(mul_p);
      OP_DOT: begin
        if (s_sel[DIFF_BITS-1] == w_sel[DIFF_BITS-1]) begin
          pos_q <= pos_q + ACC_BITS'(mul_p);
        end else begin
          neg_q <= neg_q + ACC_BITS'(mul_p);
        end
      end
      OP_DIVSET: begin
        sum_q <= '0;
        rem_q <= pn_diff;
        priority if (len2_q == '0 || pos_q <= neg_q) begin
          uq_q      <= '0;
          div_run_q <= 1'b0;
        end else if (pn_diff >= len2_q) begin
          uq_q      <= UQ_BITS'(1) << U_FRAC_BITS;
          div_run_q <= 1'b0;
        end else begin
          uq_q      <= '0;
          div_run_q <= 1'b1;
        end
      end
      OP_DIV: begin
        if (div_run_q) begin
          if (r2 >= {1'b0, len2_q}) begin
            rem_q <= ACC_BITS'(r2 - {1'b0, len2_q});
            uq_q  <= {uq_q[UQ_BITS-2:0], 1'b1};
          end else begin
            rem_q <= ACC_BITS'(r2);
            uq_q  <= {uq_q[UQ_BITS-2:0], 1'b0};
          end
        end
      end
      OP_OFS: dm_q[cmd_i.axis] <= dval[W-1] ? DMAG_BITS'(-dval) : DMAG_BITS'(dval);
      OP_SQ:  sum_q <= sum_q + ACC_BITS'(mul_p);
      OP_ROOT_INIT: begin
        n_q    <= least_q;
        rrem_q <= '0;
        root_q <= '0;
      end
      OP_ROOT: begin
        n_q <= n_q << 2;
        if (rrem2 >= rtrial) begin
          rrem_q <= (DIST_BITS + 2)'(rrem2 - rtrial);
          root_q <= {root_q[DIST_BITS-2:0], 1'b1};
        end else begin
          rrem_q <= (DIST_BITS + 2)'(rrem2);
          root_q <= {root_q[DIST_BITS-2:0], 1'b0};
        end
      end
      OP_EMIT: begin
        dist_q  <= seen_q ? root_q : '1;
        noseg_q <= !seen_q;
      end
      default: begin
        sum_q <= sum_q;
      end
    endcase
  end

  assign status_o.first    = first_q;
  assign status_o.last     = last_q;
  assign status_o.seen     = seen_q;
  assign status_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign distance_mm_o = dist_q;
  assign no_segment_o  = noseg_q;

endmodule

FILE: sv/ptpd_checker.sv
module ptpd_checker import ptpd_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic [DIST_BITS-1:0] distance_mm_i,
  input logic                 no_segment_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(distance_mm_i)
                                    && $stable(no_segment_i))
    else $error("result changed while stalled");

  a_noseg_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && no_segment_i |-> distance_mm_i == {DIST_BITS{1'b1}})
    else $error("no_segment result without saturated distance");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("vertex taken while previous vertex still in work");

endmodule

bind point_to_polyline_distance ptpd_checker u_ptpd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .distance_mm_i (out_o.distance_mm),
  .no_segment_i  (out_o.no_segment)
);

FILE: sim/ptpd_tb_if.sv
`timescale 1ns / 1ps

// Channel interfaces come from the RTL; this file holds the test's request and result types.
package ptpd_tb_pkg;
  import ptpd_pkg::*;

  typedef struct packed {
    coord_t vx, vy, vz;
    coord_t qx, qy, qz;
    logic   first;
    logic   last;
  } vertex_req_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] distance;
    logic                 no_seg;
  } dist_res_t;
endpackage

FILE: sim/ptpd_checker.sv
`timescale 1ns / 1ps

module ptpd_scoreboard import ptpd_pkg::*; import ptpd_tb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  ptpd_in_if.sink    in_i,
  ptpd_out_if.sink   out_i,
  output int         fail_cnt_o,
  output int         pending_o
);
  localparam logic [63:0] SQ_MAX = (64'd1 << SQ_BITS) - 1;

  logic        height_on;
  longint      prev_v [3];
  logic [63:0] least_sq;
  logic        seen;
  dist_res_t   dist_q [$];

  assign pending_o = dist_q.size();

  function automatic logic [63:0] mag(longint x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  function automatic logic [63:0] segment_sq(longint a[3], longint b[3], longint q[3],
                                             int dims);
    longint      s [3];
    longint      w [3];
    logic [63:0] len2, pos, neg, uq, r, sum, m;
    longint      off, d;
    len2 = 0; pos = 0; neg = 0; sum = 0;
    for (int k = 0; k < dims; k++) begin
      s[k] = b[k] - a[k];
      w[k] = q[k] - a[k];
      len2 += mag(s[k]) * mag(s[k]);
      if ((s[k] < 0) == (w[k] < 0)) pos += mag(s[k]) * mag(w[k]);
      else neg += mag(s[k]) * mag(w[k]);
    end
    if (len2 == 0 || pos <= neg) begin
      uq = 0;
    end else if (pos - neg >= len2) begin
      uq = 64'd1 << U_FRAC_BITS;
    end else begin
      r = pos - neg;
      uq = 0;
      for (int i = 0; i < U_FRAC_BITS; i++) begin
        r = r << 1;
        uq = uq << 1;
        if (r >= len2) begin
          r -= len2;
          uq |= 1;
        end
      end
    end
    for (int k = 0; k < dims; k++) begin
      m = (uq * mag(s[k]) + (64'd1 << (U_FRAC_BITS - 1))) >> U_FRAC_BITS;
      off = s[k] < 0 ? -longint'(m) : longint'(m);
      d = w[k] - off;
      sum += mag(d) * mag(d);
    end
    return sum;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  task automatic predict_vertex(vertex_req_t rq);
    longint      v [3];
    longint      q [3];
    logic [63:0] d;
    dist_res_t   res;
    v[0] = rq.vx; v[1] = rq.vy; v[2] = rq.vz;
    q[0] = rq.qx; q[1] = rq.qy; q[2] = rq.qz;
    if (rq.first) begin
      least_sq = SQ_MAX;
      seen = 0;
    end else begin
      d = segment_sq(prev_v, v, q, height_on ? 3 : 2);
      if (d > SQ_MAX) d = SQ_MAX;
      if (d < least_sq) least_sq = d;
      seen = 1;
    end
    prev_v = v;
    if (rq.last) begin
      if (seen) begin
        res.distance = DIST_BITS'(int_sqrt(least_sq));
        res.no_seg = 0;
      end else begin
        res.distance = '1;
        res.no_seg = 1;
      end
      dist_q = {dist_q, res};
      least_sq = SQ_MAX;
      seen = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dist_res_t   want;
    vertex_req_t rq;
    if (!rst_ni) begin
      height_on = 1;
      prev_v = '{0, 0, 0};
      least_sq = SQ_MAX;
      seen = 0;
      fail_cnt_o = 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        if (dist_q.size() == 0) begin
          $display("%0t: unexpected result dist=%0d no_seg=%0b", $time,
                   out_i.distance_mm, out_i.no_segment);
          fail_cnt_o++;
        end else begin
          want = dist_q.pop_front();
          if (want.distance !== out_i.distance_mm || want.no_seg !== out_i.no_segment) begin
            $display("%0t: mismatch expected dist=%0d no_seg=%0b actual dist=%0d no_seg=%0b",
                     $time, want.distance, want.no_seg, out_i.distance_mm, out_i.no_segment);
            fail_cnt_o++;
          end
        end
      end
      if (in_i.valid && in_i.ready) begin
        rq = '{in_i.vertex_x, in_i.vertex_y, in_i.vertex_z, in_i.query_x, in_i.query_y,
               in_i.query_z, in_i.first_vertex, in_i.last_vertex};
        predict_vertex(rq);
      end
      if (cfg_we_i) height_on = cfg_wdata_i;
    end
  end
endmodule

FILE: sim/point_to_polyline_distance_tb.sv
`timescale 1ns / 1ps

module point_to_polyline_distance_tb import ptpd_pkg::*; import ptpd_tb_pkg::*; ();
  localparam int RANDOM_ITEMS = 1500;
  localparam int DRAIN_CYCLES = 80;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic cfg_wdata_i = 0;
  int   fail_cnt;
  int   pending;
  bit   calm_in, calm_out;
  int   hold_off;

  ptpd_in_if  in_ch ();
  ptpd_out_if out_ch ();

  point_to_polyline_distance DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  ptpd_scoreboard u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_i(in_ch.sink), .out_i(out_ch.sink),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  initial begin
    in_ch.valid = 0;
    {in_ch.vertex_x, in_ch.vertex_y, in_ch.vertex_z} = '0;
    {in_ch.query_x, in_ch.query_y, in_ch.query_z} = '0;
    in_ch.first_vertex = 0;
    in_ch.last_vertex = 0;
    out_ch.ready = 0;
  end

  // Receiver: random stalls, one long hold-off that backs up the input.
  initial begin
    hold_off = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off > 0) begin
        hold_off--;
        out_ch.ready <= 0;
      end else begin
        out_ch.ready <= calm_out || ($urandom_range(99) >= 18);
      end
    end
  end

  function automatic coord_t rand_coord();
    case ($urandom_range(5))
      0: return coord_t'(24'h7fffff);
      1: return coord_t'(24'h800000);
      2: return coord_t'($urandom_range(200) - 100);
      3: return coord_t'($urandom_range(20000) - 10000);
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic send_vertex(vertex_req_t rq);
    in_ch.valid <= 1;
    {in_ch.vertex_x, in_ch.vertex_y, in_ch.vertex_z} <= {rq.vx, rq.vy, rq.vz};
    {in_ch.query_x, in_ch.query_y, in_ch.query_z} <= {rq.qx, rq.qy, rq.qz};
    in_ch.first_vertex <= rq.first;
    in_ch.last_vertex <= rq.last;
    do @(posedge clk_i); while (!in_ch.ready);
    // Drop valid only when the next request is delayed.
    if (!calm_in && $urandom_range(99) < 18) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic send_pt(coord_t x, y, z, coord_t qx, qy, qz, logic f, l);
    vertex_req_t rq;
    rq = '{x, y, z, qx, qy, qz, f, l};
    send_vertex(rq);
  endtask

  task automatic drain_and_config(logic h);
    in_ch.valid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic random_polyline(output int sent);
    coord_t qx, qy, qz;
    int     n;
    logic   broken;
    qx = rand_coord(); qy = rand_coord(); qz = rand_coord();
    n = ($urandom_range(9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 5);
    broken = ($urandom_range(9) == 0);
    for (int i = 0; i < n; i++) begin
      if (broken && $urandom_range(3) == 0) begin
        qx = rand_coord();
      end
      send_pt(rand_coord(), rand_coord(), rand_coord(), qx, qy, qz,
              broken ? 1'($urandom) : (i == 0), broken ? 1'($urandom) : (i == n - 1));
    end
    sent = n;
  endtask

  initial begin
    int items;
    int sent;
    calm_in = 0;
    calm_out = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Vertex before any first: segment from the reset origin.
    send_pt(10, 0, 0, 3, 4, 5, 0, 1);
    // Single-vertex polyline.
    send_pt(5, 5, 5, 0, 0, 0, 1, 1);
    // Zero-length segment.
    send_pt(7, 7, 7, 1, 2, 3, 1, 0);
    send_pt(7, 7, 7, 1, 2, 3, 0, 1);
    // Projection clamped at the start, a zero-length segment and an interior point.
    send_pt(0, 0, 0, -5, 3, 0, 1, 0);
    send_pt(100, 0, 0, -5, 3, 0, 0, 0);
    send_pt(100, 0, 0, 205, 3, 0, 0, 0);
    send_pt(-100, 0, 0, 50, 3, 9, 0, 1);
    // Full-range extremes.
    send_pt(coord_t'(24'h800000), coord_t'(24'h800000), coord_t'(24'h800000),
            coord_t'(24'h7fffff), coord_t'(24'h7fffff), coord_t'(24'h7fffff), 1, 0);
    send_pt(coord_t'(24'h800000), coord_t'(24'h800000), coord_t'(24'h800000),
            coord_t'(24'h7fffff), coord_t'(24'h7fffff), coord_t'(24'h7fffff), 0, 1);
    send_pt(coord_t'(24'h7fffff), coord_t'(24'h800000), coord_t'(24'h7fffff),
            coord_t'(24'h800000), coord_t'(24'h7fffff), coord_t'(24'h800000), 1, 0);
    send_pt(coord_t'(24'h800000), coord_t'(24'h7fffff), coord_t'(24'h800000),
            coord_t'(24'h7fffff), coord_t'(24'h800000), coord_t'(24'h7fffff), 0, 1);
    // Query changes mid-polyline.
    send_pt(0, 0, 0, 1, 1, 1, 1, 0);
    send_pt(50, 50, 0, 9, 9, 9, 0, 1);

    drain_and_config(0);
    send_pt(0, 0, 0, 5, 5, 1000, 1, 0);
    send_pt(10, 0, 500, 5, 5, 1000, 0, 1);
    send_pt(coord_t'(24'h7fffff), 0, coord_t'(24'h800000), 0, coord_t'(24'h800000),
            coord_t'(24'h7fffff), 1, 0);
    send_pt(coord_t'(24'h800000), coord_t'(24'h7fffff), 0, 0, coord_t'(24'h800000),
            coord_t'(24'h7fffff), 0, 1);
    drain_and_config(1);

    // Long receiver stall while the sender keeps offering requests.
    hold_off = 400;
    for (int i = 0; i < 12; i++) send_pt(rand_coord(), rand_coord(), rand_coord(),
                                         1, 2, 3, i % 3 == 0, i % 3 == 2);

    items = 0;
    for (int phase = 0; phase < 4; phase++) begin
      calm_in = (phase == 2);
      calm_out = (phase == 2);
      while (items < (phase + 1) * RANDOM_ITEMS / 4) begin
        random_polyline(sent);
        items += sent;
      end
      drain_and_config(phase[0]);
    end

    in_ch.valid <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
